/* rtl/cme_pkg.sv */
// Shared types, widths and constants for the correlation matrix engine.
// No dependencies; used by cme_mul, cme_ratio, correlation_matrix_engine, cme_checker and tb.
package cme_pkg;

   // fixed field widths
   localparam int SAMPLE_W   = 16;
   localparam int SUM_W      = 33;
   localparam int XSUM_W     = 48;
   localparam int CORR_W     = 16;
   localparam int MAG_W      = 15;
   localparam int IDX_W      = 3;
   localparam int CFG_W      = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int TDATA_W    = 24;
   localparam int TRI_IDX_W  = 6;

   // arithmetic unit widths
   localparam int HALF_W     = 64;
   localparam int WIDE_W     = 128;
   localparam int QUO_W      = 31;
   localparam int ROOT_W     = 32;
   localparam int DIV_STEPS  = 31;
   localparam int ROOT_STEPS = 16;
   localparam int STEP_W     = 5;

   localparam logic [CFG_W-1:0] CFG_RESET = 4'd3;

   // register indexes
   localparam int REG_SERIES = 0;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_TOO_FEW    = 2'd1,
      ST_ZERO_VAR   = 2'd2,
      ST_INCOMPLETE = 2'd3
   } status_type;

   // packed upper-triangle address of pair (a, b), order-free
   function automatic logic [TRI_IDX_W-1:0] tri_addr(input logic [IDX_W-1:0] a,
                                                     input logic [IDX_W-1:0] b);
      logic [TRI_IDX_W-1:0] lo;
      logic [TRI_IDX_W-1:0] hi;
      logic [TRI_IDX_W-1:0] base;
      lo = (a < b) ? TRI_IDX_W'(a) : TRI_IDX_W'(b);
      hi = (a < b) ? TRI_IDX_W'(b) : TRI_IDX_W'(a);
      base = (hi * (hi + TRI_IDX_W'(1))) >> 1;
      return base + lo;
   endfunction

endpackage

/* rtl/cme_mul.sv */
// Shared shift-add multiplier, 64 x 64 -> 128 unsigned, one multiplier bit a cycle.
// Stops as soon as the remaining multiplier bits are zero. Depends on cme_pkg.
module cme_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [cme_pkg::HALF_W-1:0]  mcand,
   input  logic [cme_pkg::HALF_W-1:0]  mplier,
   output logic                        done,
   output logic [cme_pkg::WIDE_W-1:0]  product
);

   logic                       busy_ff;
   logic                       done_ff;
   logic [cme_pkg::WIDE_W-1:0] mcand_ff;
   logic [cme_pkg::HALF_W-1:0] mplier_ff;
   logic [cme_pkg::WIDE_W-1:0] acc_ff;
   logic [cme_pkg::WIDE_W-1:0] acc_in;
   logic [cme_pkg::HALF_W-1:0] mplier_in;

   // one partial product per cycle
   always_comb begin
      acc_in    = acc_ff + (mplier_ff[0] ? mcand_ff : '0);
      mplier_in = mplier_ff >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            mcand_ff  <= cme_pkg::WIDE_W'(mcand);
            mplier_ff <= mplier;
            acc_ff    <= '0;
            busy_ff   <= 1'b1;
         end else if (busy_ff) begin
            acc_ff    <= acc_in;
            mcand_ff  <= mcand_ff << 1;
            mplier_ff <= mplier_in;
            if (mplier_in == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

/* rtl/cme_ratio.sv */
// Correlation magnitude unit: floor(2^30 * num2 / den) by restoring division,
// then an integer square root, then rounding to Q1.14. Depends on cme_pkg.
module cme_ratio (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [cme_pkg::WIDE_W-1:0]  num2,
   input  logic [cme_pkg::WIDE_W-1:0]  den,
   output logic                        done,
   output logic [cme_pkg::MAG_W-1:0]   mag
);

   typedef enum logic [1:0] {R_IDLE, R_DIV, R_ROOT} phase_type;

   phase_type                    phase_ff;
   logic [cme_pkg::STEP_W-1:0]   step_ff;
   logic                         first_ff;
   logic                         done_ff;
   logic [cme_pkg::WIDE_W-1:0]   rem_ff;
   logic [cme_pkg::WIDE_W-1:0]   den_ff;
   logic [cme_pkg::QUO_W-1:0]    quo_ff;
   logic [cme_pkg::ROOT_W-1:0]   op_ff;
   logic [cme_pkg::ROOT_W-1:0]   res_ff;
   logic [cme_pkg::ROOT_W-1:0]   one_ff;
   logic [cme_pkg::MAG_W-1:0]    mag_ff;

   logic [cme_pkg::WIDE_W-1:0]   shifted;
   logic                         ge;
   logic [cme_pkg::WIDE_W-1:0]   rem_in;
   logic [cme_pkg::QUO_W-1:0]    quo_in;
   logic [cme_pkg::ROOT_W-1:0]   trial;
   logic                         fits;
   logic [cme_pkg::ROOT_W-1:0]   op_in;
   logic [cme_pkg::ROOT_W-1:0]   res_in;
   logic [cme_pkg::ROOT_W-1:0]   res_rnd;

   // one quotient bit, or one root bit, per cycle
   always_comb begin
      shifted = first_ff ? rem_ff : (rem_ff << 1);
      ge      = (shifted >= den_ff);
      rem_in  = ge ? (shifted - den_ff) : shifted;
      quo_in  = {quo_ff[cme_pkg::QUO_W-2:0], ge};
      trial   = res_ff + one_ff;
      fits    = (op_ff >= trial);
      op_in   = fits ? (op_ff - trial) : op_ff;
      res_in  = fits ? ((res_ff >> 1) + one_ff) : (res_ff >> 1);
      res_rnd = (res_in + cme_pkg::ROOT_W'(1)) >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= R_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (phase_ff)
            R_IDLE: begin
               if (start) begin
                  rem_ff   <= num2;
                  den_ff   <= den;
                  quo_ff   <= '0;
                  first_ff <= 1'b1;
                  step_ff  <= cme_pkg::STEP_W'(cme_pkg::DIV_STEPS - 1);
                  phase_ff <= R_DIV;
               end
            end
            R_DIV: begin
               rem_ff   <= rem_in;
               quo_ff   <= quo_in;
               first_ff <= 1'b0;
               if (step_ff == '0) begin
                  op_ff    <= cme_pkg::ROOT_W'(quo_in);
                  res_ff   <= '0;
                  one_ff   <= cme_pkg::ROOT_W'(1) << (cme_pkg::ROOT_W - 2);
                  step_ff  <= cme_pkg::STEP_W'(cme_pkg::ROOT_STEPS - 1);
                  phase_ff <= R_ROOT;
               end else begin
                  step_ff <= step_ff - cme_pkg::STEP_W'(1);
               end
            end
            R_ROOT: begin
               op_ff  <= op_in;
               res_ff <= res_in;
               one_ff <= one_ff >> 2;
               if (step_ff == '0) begin
                  mag_ff   <= cme_pkg::MAG_W'(res_rnd);
                  done_ff  <= 1'b1;
                  phase_ff <= R_IDLE;
               end else begin
                  step_ff <= step_ff - cme_pkg::STEP_W'(1);
               end
            end
            default: phase_ff <= R_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign mag  = mag_ff;

endmodule

/* rtl/correlation_matrix_engine.sv */
// Pearson correlation matrix engine: exact sums, then a Q1.14 matrix on the final beat.
// Depends on cme_pkg, cme_mul and cme_ratio.
//
// Samples arrive one per beat in series order. The beat that closes an observation
// starts an update pass, during which req_tready stays low: a 16x16 multiplier and a
// read-modify-write port on the 36-entry cross-sum memory update one product sum per
// cycle, after a row-load step per series. On the final beat the block first forms the
// n variances, then each of the n*n entries that is not flagged through one shared
// shift-add multiplier (four products an entry) and a magnitude unit. No clearing pass
// is needed after reset or after a matrix; valid bits cover the cross-sum memory.
module correlation_matrix_engine #(
   parameter int MAX_SERIES       = 8,
   parameter int MAX_OBSERVATIONS = 65536
) (
   input  logic                               clock,
   input  logic                               reset,
   // input stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [cme_pkg::SAMPLE_W-1:0]       req_tdata,   // [15:0] sample_value
   input  logic                               req_tlast,   // last_in_set
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [cme_pkg::TDATA_W-1:0]        rsp_tdata,   // [2:0] row_series,
                                                           // [5:3] column_series,
                                                           // [21:6] correlation, rest 0
   output logic [1:0]                         rsp_tuser,   // [1:0] status
   output logic                               rsp_tlast,   // last_result
   // configuration
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [cme_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [cme_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [cme_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   localparam int SER_W = (MAX_SERIES > 1) ? $clog2(MAX_SERIES) : 1;
   localparam int N_W   = $clog2(MAX_SERIES + 1);
   localparam int TRI   = MAX_SERIES * (MAX_SERIES + 1) / 2;
   localparam int TRI_W = $clog2(TRI);
   localparam int CNT_W = $clog2(MAX_OBSERVATIONS + 1);
   localparam int HW    = cme_pkg::HALF_W;

   typedef enum logic [4:0] {
      S_IDLE, S_ROW, S_PAIR, S_DRAIN,
      S_VRD, S_VM1, S_VM2,
      S_EROW, S_ECHK, S_ERD, S_EM1, S_EM2, S_EM3, S_EM4, S_DIV, S_OUT, S_CLR
   } state_type;

   state_type                             state_ff;
   logic [cme_pkg::CFG_W-1:0]             sio_ff;
   logic [CNT_W-1:0]                      count_ff;
   logic [SER_W-1:0]                      pos_ff;
   logic [SER_W-1:0]                      i_ff;
   logic [SER_W-1:0]                      j_ff;
   logic                                  last_ff;
   logic                                  inc_ff;
   logic                                  go_ff;
   logic signed [cme_pkg::SAMPLE_W-1:0]   cur_ff [MAX_SERIES];
   logic signed [cme_pkg::SUM_W-1:0]      ssum_ff [MAX_SERIES];
   logic [HW-1:0]                         var_ff [MAX_SERIES];
   logic signed [cme_pkg::SAMPLE_W-1:0]   xi_ff;
   logic signed [cme_pkg::XSUM_W-1:0]     prod_ff;
   logic [TRI_W-1:0]                      waddr_ff;
   logic                                  pend_ff;
   logic signed [cme_pkg::XSUM_W-1:0]     xmem [TRI];
   logic [TRI-1:0]                        xvalid_ff;
   logic signed [cme_pkg::XSUM_W-1:0]     xrd_ff;
   logic                                  xrdv_ff;
   logic signed [HW-1:0]                  t1_ff;
   logic [HW-1:0]                         absn_ff;
   logic                                  neg_ff;
   logic [cme_pkg::WIDE_W-1:0]            a2_ff;
   logic [HW-1:0]                         vi_ff;
   logic signed [cme_pkg::SUM_W-1:0]      si_ff;
   cme_pkg::status_type                   st_ff;
   logic [cme_pkg::MAG_W-1:0]             mag_ff;
   logic                                  rsp_valid_ff;
   logic [cme_pkg::IDX_W-1:0]             out_row_ff;
   logic [cme_pkg::IDX_W-1:0]             out_col_ff;
   logic [cme_pkg::CORR_W-1:0]            out_corr_ff;
   cme_pkg::status_type                   out_st_ff;
   logic                                  out_last_ff;

   logic [N_W-1:0]                        n_act;
   logic [SER_W-1:0]                      n_last;
   logic                                  use_i;
   logic [SER_W-1:0]                      idx;
   logic signed [cme_pkg::SAMPLE_W-1:0]   cur_rd;
   logic signed [cme_pkg::SUM_W-1:0]      ssum_rd;
   logic [HW-1:0]                         var_rd;
   logic [TRI_W-1:0]                      rd_addr;
   logic signed [cme_pkg::XSUM_W-1:0]     xsum;
   logic [cme_pkg::XSUM_W-1:0]            xsum_mag;
   logic [cme_pkg::SUM_W-1:0]             ssum_mag;
   logic [cme_pkg::SUM_W-1:0]             si_mag;
   logic signed [2*cme_pkg::SAMPLE_W-1:0] pp;
   logic                                  req_acc;
   logic                                  complete;
   logic                                  mul_start;
   logic [HW-1:0]                         mul_a;
   logic [HW-1:0]                         mul_b;
   logic                                  mul_done;
   logic [cme_pkg::WIDE_W-1:0]            mul_prod;
   logic signed [HW-1:0]                  mul_lo;
   logic signed [HW-1:0]                  pterm;
   logic signed [HW-1:0]                  num_in;
   logic                                  ratio_start;
   logic                                  ratio_done;
   logic [cme_pkg::MAG_W-1:0]             ratio_mag;
   logic                                  out_free;
   logic                                  csr_wr;

   // active series count, clamped
   always_comb begin
      if (sio_ff < cme_pkg::CFG_W'(2)) begin
         n_act = N_W'(2);
      end else if (sio_ff > cme_pkg::CFG_W'(MAX_SERIES)) begin
         n_act = N_W'(MAX_SERIES);
      end else begin
         n_act = N_W'(sio_ff);
      end
      n_last = SER_W'(n_act - N_W'(1));
   end

   // single read port on the small per-series arrays
   always_comb begin
      use_i   = (state_ff == S_ROW) || (state_ff == S_VM2) || (state_ff == S_EROW);
      idx     = use_i ? i_ff : j_ff;
      cur_rd  = cur_ff[idx];
      ssum_rd = ssum_ff[idx];
      var_rd  = var_ff[idx];
      if (state_ff == S_VRD) begin
         rd_addr = TRI_W'(cme_pkg::tri_addr(cme_pkg::IDX_W'(i_ff), cme_pkg::IDX_W'(i_ff)));
      end else begin
         rd_addr = TRI_W'(cme_pkg::tri_addr(cme_pkg::IDX_W'(i_ff), cme_pkg::IDX_W'(j_ff)));
      end
      xsum     = xrdv_ff ? xrd_ff : '0;
      xsum_mag = xsum[cme_pkg::XSUM_W-1] ? -xsum : xsum;
      ssum_mag = ssum_rd[cme_pkg::SUM_W-1] ? -ssum_rd : ssum_rd;
      si_mag   = si_ff[cme_pkg::SUM_W-1] ? -si_ff : si_ff;
      pp       = xi_ff * cur_rd;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign complete   = (pos_ff >= n_last);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_VM1: begin
            mul_a = HW'(unsigned'(xsum));
            mul_b = HW'(count_ff);
         end
         S_VM2: begin
            mul_a = HW'(ssum_mag);
            mul_b = HW'(ssum_mag);
         end
         S_EM1: begin
            mul_a = HW'(xsum_mag);
            mul_b = HW'(count_ff);
         end
         S_EM2: begin
            mul_a = HW'(si_mag);
            mul_b = HW'(ssum_mag);
         end
         S_EM3: begin
            mul_a = absn_ff;
            mul_b = absn_ff;
         end
         S_EM4: begin
            mul_a = vi_ff;
            mul_b = var_rd;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_start = !go_ff && ((state_ff == S_VM1) || (state_ff == S_VM2) ||
                             (state_ff == S_EM1) || (state_ff == S_EM2) ||
                             (state_ff == S_EM3) || (state_ff == S_EM4));
      ratio_start = !go_ff && (state_ff == S_DIV);
      mul_lo = mul_prod[HW-1:0];
      pterm  = (si_ff[cme_pkg::SUM_W-1] ^ ssum_rd[cme_pkg::SUM_W-1]) ? -mul_lo : mul_lo;
      num_in = t1_ff - pterm;
   end

   cme_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_a),
      .mplier  (mul_b),
      .done    (mul_done),
      .product (mul_prod)
   );

   cme_ratio u_ratio (
      .clock (clock),
      .reset (reset),
      .start (ratio_start),
      .num2  (a2_ff),
      .den   (mul_prod),
      .done  (ratio_done),
      .mag   (ratio_mag)
   );

   // configuration register
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   always_comb begin
      if (csr_paddr[cme_pkg::CSR_ADDR_W-1:2] == 1'(cme_pkg::REG_SERIES)) begin
         csr_prdata = cme_pkg::CSR_DATA_W'(sio_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sio_ff <= cme_pkg::CFG_RESET;
      end else if (csr_wr &&
                   csr_paddr[cme_pkg::CSR_ADDR_W-1:2] == 1'(cme_pkg::REG_SERIES)) begin
         sio_ff <= csr_pwdata[cme_pkg::CFG_W-1:0];
      end
   end

   // cross-sum memory: one read and one accumulate write per cycle
   always_ff @(posedge clock) begin
      prod_ff  <= cme_pkg::XSUM_W'(pp);
      waddr_ff <= rd_addr;
      xrd_ff   <= xmem[rd_addr];
      if (pend_ff) begin
         xmem[waddr_ff] <= xsum + prod_ff;
      end
   end

   // entry valid bits stand in for a cleared memory
   always_ff @(posedge clock) begin
      if (reset || state_ff == S_CLR) begin
         xvalid_ff <= '0;
         xrdv_ff   <= 1'b0;
         pend_ff   <= 1'b0;
      end else begin
         pend_ff <= (state_ff == S_PAIR);
         xrdv_ff <= xvalid_ff[rd_addr];
         if (pend_ff) begin
            xvalid_ff[waddr_ff] <= 1'b1;
         end
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         pos_ff       <= '0;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < MAX_SERIES; k++) begin
            ssum_ff[k] <= '0;
         end
      end else begin
         if (mul_start || ratio_start) begin
            go_ff <= 1'b1;
         end else if (mul_done || ratio_done) begin
            go_ff <= 1'b0;
         end
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_acc) begin
                  cur_ff[pos_ff] <= req_tdata;
                  last_ff        <= req_tlast;
                  inc_ff         <= !complete;
                  i_ff           <= '0;
                  if (complete) begin
                     pos_ff <= '0;
                     if (count_ff != CNT_W'(MAX_OBSERVATIONS)) begin
                        count_ff <= count_ff + CNT_W'(1);
                        state_ff <= S_ROW;
                     end else if (req_tlast) begin
                        state_ff <= S_VRD;
                     end
                  end else begin
                     pos_ff <= pos_ff + SER_W'(1);
                     if (req_tlast) begin
                        state_ff <= S_VRD;
                     end
                  end
               end
            end
            // accumulate one observation, row by row
            S_ROW: begin
               xi_ff         <= cur_rd;
               ssum_ff[i_ff] <= ssum_ff[i_ff] + cme_pkg::SUM_W'(cur_rd);
               j_ff          <= i_ff;
               state_ff      <= S_PAIR;
            end
            S_PAIR: begin
               if (j_ff == n_last) begin
                  if (i_ff == n_last) begin
                     state_ff <= S_DRAIN;
                  end else begin
                     i_ff     <= i_ff + SER_W'(1);
                     state_ff <= S_ROW;
                  end
               end else begin
                  j_ff <= j_ff + SER_W'(1);
               end
            end
            S_DRAIN: begin
               i_ff     <= '0;
               state_ff <= last_ff ? S_VRD : S_IDLE;
            end
            // variance of each series
            S_VRD: state_ff <= S_VM1;
            S_VM1: begin
               if (mul_done) begin
                  t1_ff    <= mul_lo;
                  state_ff <= S_VM2;
               end
            end
            S_VM2: begin
               if (mul_done) begin
                  var_ff[i_ff] <= t1_ff - mul_lo;
                  if (i_ff == n_last) begin
                     i_ff     <= '0;
                     state_ff <= S_EROW;
                  end else begin
                     i_ff     <= i_ff + SER_W'(1);
                     state_ff <= S_VRD;
                  end
               end
            end
            // matrix entries
            S_EROW: begin
               vi_ff    <= var_rd;
               si_ff    <= ssum_rd;
               j_ff     <= '0;
               state_ff <= S_ECHK;
            end
            S_ECHK: begin
               mag_ff <= '0;
               neg_ff <= 1'b0;
               if (count_ff < CNT_W'(2)) begin
                  st_ff    <= cme_pkg::ST_TOO_FEW;
                  state_ff <= S_OUT;
               end else if (vi_ff == '0 || var_rd == '0) begin
                  st_ff    <= cme_pkg::ST_ZERO_VAR;
                  state_ff <= S_OUT;
               end else begin
                  state_ff <= S_ERD;
               end
            end
            S_ERD: state_ff <= S_EM1;
            S_EM1: begin
               if (mul_done) begin
                  t1_ff    <= xsum[cme_pkg::XSUM_W-1] ? -mul_lo : mul_lo;
                  state_ff <= S_EM2;
               end
            end
            S_EM2: begin
               if (mul_done) begin
                  neg_ff   <= num_in[HW-1];
                  absn_ff  <= num_in[HW-1] ? -num_in : num_in;
                  state_ff <= S_EM3;
               end
            end
            S_EM3: begin
               if (mul_done) begin
                  a2_ff    <= mul_prod;
                  state_ff <= S_EM4;
               end
            end
            S_EM4: begin
               if (mul_done) begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (ratio_done) begin
                  mag_ff   <= ratio_mag;
                  st_ff    <= inc_ff ? cme_pkg::ST_INCOMPLETE : cme_pkg::ST_OK;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  out_row_ff   <= cme_pkg::IDX_W'(i_ff);
                  out_col_ff   <= cme_pkg::IDX_W'(j_ff);
                  out_corr_ff  <= neg_ff ? -cme_pkg::CORR_W'(mag_ff)
                                         : cme_pkg::CORR_W'(mag_ff);
                  out_st_ff    <= st_ff;
                  out_last_ff  <= (i_ff == n_last) && (j_ff == n_last);
                  if (j_ff == n_last) begin
                     if (i_ff == n_last) begin
                        state_ff <= S_CLR;
                     end else begin
                        i_ff     <= i_ff + SER_W'(1);
                        state_ff <= S_EROW;
                     end
                  end else begin
                     j_ff     <= j_ff + SER_W'(1);
                     state_ff <= S_ECHK;
                  end
               end
            end
            // start a fresh run
            S_CLR: begin
               count_ff <= '0;
               pos_ff   <= '0;
               for (int k = 0; k < MAX_SERIES; k++) begin
                  ssum_ff[k] <= '0;
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(cme_pkg::TDATA_W - cme_pkg::CORR_W - 2*cme_pkg::IDX_W){1'b0}},
                        out_corr_ff, out_col_ff, out_row_ff};
   assign rsp_tuser  = out_st_ff;
   assign rsp_tlast  = out_last_ff;

   // checks
   a_pend_from_pair: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(state_ff == S_PAIR))
      else $error("cross-sum write without a pair issue");

   a_flagged_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == cme_pkg::ST_TOO_FEW || rsp_tuser == cme_pkg::ST_ZERO_VAR))
      |-> (rsp_tdata[21:6] == '0))
      else $error("flagged entry carries a nonzero correlation");

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !pend_ff)
      else $error("input taken while a cross-sum write is pending");

endmodule

/* sim/cme_checker.sv */
// Checker for the correlation matrix engine: watches the sample, result and CSR buses,
// predicts each matrix entry from exact sums and compares it field by field.
// Depends on cme_pkg for the status codes, the register index and the widths.
`timescale 1ns / 100ps

module cme_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [cme_pkg::SAMPLE_W-1:0]   req_tdata,
   input  logic                           req_tlast,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [cme_pkg::TDATA_W-1:0]    rsp_tdata,
   input  logic [1:0]                     rsp_tuser,
   input  logic                           rsp_tlast,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic                           csr_pready,
   input  logic [cme_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [cme_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output int                             fail_count,
   output int                             entries_pending
);
   import cme_pkg::*;

   localparam int SERIES_MAX = 8;
   localparam longint OBS_CAP = 65536;

   typedef struct {
      logic [2:0]  row;
      logic [2:0]  col;
      logic [15:0] corr;
      status_type  status;
      logic        last;
   } entry_t;

   entry_t matrix_q[$];

   // predictor state
   logic [CFG_W-1:0] series_reg;
   longint           obs_count;
   int               obs_pos;
   bit signed [63:0] obs_buf [SERIES_MAX];
   bit [63:0]        sum_s   [SERIES_MAX];
   bit [63:0]        prod_s  [SERIES_MAX][SERIES_MAX];   // upper triangle, row <= col

   assign entries_pending = matrix_q.size();

   function automatic int series_now();
      if (series_reg < 2) return 2;
      if (series_reg > SERIES_MAX) return SERIES_MAX;
      return int'(series_reg);
   endfunction

   function automatic bit [63:0] prod_at(int i, int j);
      return (i <= j) ? prod_s[i][j] : prod_s[j][i];
   endfunction

   // largest k in 0..16384 with (2k-1)^2 * vi * vj <= 2^30 * a^2
   function automatic int round_mag(bit [63:0] a, bit [63:0] vi, bit [63:0] vj);
      bit [191:0] den;
      bit [191:0] num;
      bit [191:0] lhs;
      bit [63:0]  odd;
      int lo, hi, mid;
      den = 192'(vi) * 192'(vj);
      num = (192'(a) * 192'(a)) << 30;
      lo = 0;
      hi = 16384;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         odd = 64'(2 * mid - 1);
         lhs = den * 192'(odd * odd);
         if (lhs <= num) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   task automatic take_sample(logic [15:0] raw, logic fin);
      int n;
      bit [63:0] m, vi, vj, dev, mag;
      entry_t e;
      n = series_now();
      obs_buf[obs_pos & 7] = 64'(signed'(raw));
      if (obs_pos + 1 >= n) begin
         if (obs_count < OBS_CAP) begin
            for (int i = 0; i < n; i++) begin
               sum_s[i] += obs_buf[i];
               for (int j = i; j < n; j++) prod_s[i][j] += obs_buf[i] * obs_buf[j];
            end
            obs_count++;
         end
         obs_pos = 0;
      end else begin
         obs_pos++;
      end
      if (!fin) return;

      // whole matrix, row by row
      m = 64'(obs_count);
      for (int i = 0; i < n; i++) begin
         for (int j = 0; j < n; j++) begin
            vi = m * prod_at(i, i) - sum_s[i] * sum_s[i];
            vj = m * prod_at(j, j) - sum_s[j] * sum_s[j];
            e.row = 3'(i);
            e.col = 3'(j);
            e.corr = '0;
            e.last = (i == n - 1) && (j == n - 1);
            if (obs_count < 2) begin
               e.status = ST_TOO_FEW;
            end else if (vi == 0 || vj == 0) begin
               e.status = ST_ZERO_VAR;
            end else begin
               dev = m * prod_at(i, j) - sum_s[i] * sum_s[j];
               mag = 64'(round_mag(dev[63] ? -dev : dev, vi, vj));
               if (dev[63]) mag = -mag;
               e.corr = mag[15:0];
               e.status = (obs_pos != 0) ? ST_INCOMPLETE : ST_OK;
            end
            matrix_q.push_back(e);
         end
      end
      clear_sums();
   endtask

   task automatic clear_sums();
      obs_count = 0;
      obs_pos = 0;
      for (int i = 0; i < SERIES_MAX; i++) begin
         sum_s[i] = '0;
         for (int j = 0; j < SERIES_MAX; j++) prod_s[i][j] = '0;
      end
   endtask

   task automatic check_entry();
      entry_t e;
      if (matrix_q.size() == 0) begin
         $error("unexpected result beat: tdata %h tuser %0d", rsp_tdata, rsp_tuser);
         fail_count++;
         return;
      end
      e = matrix_q.pop_front();
      if (rsp_tdata[2:0] !== e.row) begin
         $error("row_series: expected %0d, got %0d", e.row, rsp_tdata[2:0]);
         fail_count++;
      end
      if (rsp_tdata[5:3] !== e.col) begin
         $error("column_series: expected %0d, got %0d", e.col, rsp_tdata[5:3]);
         fail_count++;
      end
      if (rsp_tdata[21:6] !== e.corr) begin
         $error("correlation: expected %0d, got %0d",
                $signed(e.corr), $signed(rsp_tdata[21:6]));
         fail_count++;
      end
      if (rsp_tuser !== e.status) begin
         $error("status: expected %0d, got %0d", e.status, rsp_tuser);
         fail_count++;
      end
      if (rsp_tlast !== e.last) begin
         $error("last_result: expected %0d, got %0d", e.last, rsp_tlast);
         fail_count++;
      end
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         series_reg = CFG_RESET;
         clear_sums();
         matrix_q.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == CSR_ADDR_W'(4 * REG_SERIES))
            series_reg = csr_pwdata[CFG_W-1:0];
         if (req_tvalid && req_tready) take_sample(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) check_entry();
      end
   end

endmodule

/* sim/tb.sv */
// Testbench top for the correlation matrix engine: clock, reset, sample and CSR stimulus.
// Depends on cme_pkg, correlation_matrix_engine and cme_checker.
`timescale 1ns / 100ps

module tb;
   import cme_pkg::*;

   localparam longint CYCLE_LIMIT = 6000000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [SAMPLE_W-1:0]   req_tdata = '0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [TDATA_W-1:0]    rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int     fail_count;
   int     entries_pending;
   int     send_idle = 0;
   int     recv_idle = 0;
   int     beats_sent = 0;
   int     n_cur = 3;
   longint cycles = 0;

   always #5 clock = ~clock;

   correlation_matrix_engine DUT (.*);

   cme_checker checker_i (.*);

   // receiver stalls; cycle limit
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_beat(logic [15:0] value, logic fin);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= fin;
      do @(posedge clock); while (!req_tready);
      beats_sent++;
   endtask

   task automatic stop_beats();
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
   endtask

   // drain every expected entry, then allow for a late observation update
   task automatic settle();
      stop_beats();
      @(posedge clock);
      while (entries_pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_series(logic [3:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'(4 * REG_SERIES);
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      n_cur = (value < 2) ? 2 : (value > 8) ? 8 : int'(value);
   endtask

   function automatic logic [15:0] rand_sample();
      case ($urandom_range(9))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // one set: obs full observations, optional partial tail, last beat marked
   task automatic send_set(int obs, int tail, bit flat_col);
      int total;
      int k;
      logic [15:0] v;
      total = obs * n_cur + tail;
      k = 0;
      for (int o = 0; o <= obs; o++) begin
         for (int s = 0; s < n_cur && k < total; s++) begin
            v = (flat_col && s == 1) ? 16'h1234 : rand_sample();
            k++;
            send_beat(v, k == total);
         end
      end
      settle();
   endtask

   logic [3:0] cfg_seq [$] = '{4'd0, 4'd15, 4'd8, 4'd1, 4'd2, 4'd9, 4'd5};

   initial begin
      logic [3:0] cfg;
      int obs;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, default three series
      send_beat(16'h7FFF, 1'b1);          // no complete observation
      settle();
      send_beat(16'h8000, 1'b0);          // one observation only
      send_beat(16'h7FFF, 1'b0);
      send_beat(16'h0001, 1'b1);
      settle();
      // anti-correlated extremes, constant third series
      send_beat(16'h7FFF, 1'b0); send_beat(16'h8000, 1'b0); send_beat(16'h0005, 1'b0);
      send_beat(16'h8000, 1'b0); send_beat(16'h7FFF, 1'b0); send_beat(16'h0005, 1'b0);
      send_beat(16'h7FFF, 1'b0); send_beat(16'h8000, 1'b0); send_beat(16'h0005, 1'b1);
      settle();
      // two observations plus a dangling sample
      send_beat(16'hFFFF, 1'b0); send_beat(16'h0000, 1'b0); send_beat(16'h5555, 1'b0);
      send_beat(16'h0000, 1'b0); send_beat(16'hFFFF, 1'b0); send_beat(16'hAAAA, 1'b0);
      send_beat(16'h1234, 1'b1);
      settle();

      // random sets across idling phases and series counts
      while (beats_sent < 260) begin
         if (beats_sent < 100) begin
            send_idle = 29; recv_idle = 53;
         end else if (beats_sent < 190) begin
            send_idle = 53; recv_idle = 29;
         end else begin
            send_idle = 0; recv_idle = 0;
         end
         cfg = (cfg_seq.size() != 0) ? cfg_seq.pop_front() : 4'($urandom_range(15));
         write_series(cfg);
         obs = ($urandom_range(9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
         send_set(obs, ($urandom_range(4) == 0) ? $urandom_range(1, n_cur - 1) : 0,
                  $urandom_range(7) == 0);
      end

      // observation cap: more complete observations than the sums take
      send_idle = 0; recv_idle = 0;
      write_series(4'd2);
      send_set(65538, 0, 1'b0);
      write_series(4'd3);

      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/cme_pkg.sv
rtl/cme_mul.sv
rtl/cme_ratio.sv
rtl/correlation_matrix_engine.sv
sim/cme_checker.sv
sim/tb.sv
